FILE: rtl/indel_trace_to_match_blocks_defines.svh
// Assertion macros shared by the RTL of the indel trace to match block converter.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef INDEL_TRACE_TO_MATCH_BLOCKS_DEFINES_SVH
`define INDEL_TRACE_TO_MATCH_BLOCKS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define ITMB_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("itmb assertion failed");
// Condition in one cycle implies a consequence in the next cycle.
`define ITMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("itmb assertion failed");
`else
`define ITMB_ASSERT(label, clk, rst_n, prop)
`define ITMB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/itmb_pkg.sv
// Types and codes for the indel trace to match block converter.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none
package itmb_pkg;

	// Input operation codes.
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_TRACE  = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	// Result kinds.
	localparam logic KIND_BLOCK   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// One input item.
	typedef struct packed {
		logic [1:0]         opcode;
		logic [30:0]        a_begin;
		logic [30:0]        a_end;
		logic [30:0]        b_begin;
		logic [30:0]        b_end;
		logic [30:0]        diff_total;
		logic signed [31:0] trace_value;
	} item_t;

	// One result item.
	typedef struct packed {
		logic               kind;
		logic [30:0]        block_size;
		logic [30:0]        a_start;
		logic [30:0]        b_start;
		logic signed [31:0] matches_res;
		logic signed [31:0] mismatches;
		logic [30:0]        ins_runs;
		logic [30:0]        ins_count;
		logic [30:0]        del_runs;
		logic [30:0]        del_count;
		logic [30:0]        block_count;
		logic               last;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/itmb_item_if.sv
// Valid/ready channel that carries input items.
// Depends on itmb_pkg for the item type.
`default_nettype none
interface itmb_item_if;
	logic                valid;
	logic                ready;
	itmb_pkg::item_t     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/itmb_result_if.sv
// Valid/ready channel that carries result items.
// Depends on itmb_pkg for the result type.
`default_nettype none
interface itmb_result_if;
	logic                valid;
	logic                ready;
	itmb_pkg::result_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/indel_trace_to_match_blocks.sv
// Indel trace to gap-free match block converter, top level.
// Depends on itmb_pkg, itmb_item_if, itmb_result_if and the defines header.
//
// The block takes one item per clock cycle while its result slots have room. An
// accepted item lands in an input register, from which a single pass of adders
// and compares updates the cursors and counters and loads zero, one or two results
// into a two-slot result register, whose head is shown on the output. A trace
// item yields at most one result, so a stream of trace items runs at one transfer
// per cycle on both sides while the output accepts every result. A finish item
// yields a closing block when its run is positive, then a summary, which leave in
// consecutive result transfers; the input register moves on only when the slots
// are empty or their single remaining result transfers in that same cycle, so a
// finish with a closing block stalls the input until its block has left. A start
// or an unused opcode produces no result. There is no clearing pass after reset.
`default_nettype none
`include "indel_trace_to_match_blocks_defines.svh"
module indel_trace_to_match_blocks (
	input  wire logic   clk,
	input  wire logic   arst_n,
	itmb_item_if.sink   item,
	itmb_result_if.source result
);

	// Input register.
	logic            valid_s1;
	itmb_pkg::item_t item_s1;

	// Alignment state. The interval bounds are kept in the derived form the
	// finish step needs: the A end and the combined term M+N-2*diff_total.
	logic [31:0] a_cursor_q;
	logic [31:0] b_cursor_q;
	logic [31:0] previous_value_q;
	logic [31:0] ins_total_q;
	logic [31:0] del_total_q;
	logic [31:0] indel_total_q;
	logic [30:0] ins_run_total_q;
	logic [30:0] del_run_total_q;
	logic [30:0] blocks_seen_q;
	logic [30:0] a_end_q;
	logic [31:0] diff_total_q;
	logic [31:0] mn_term_q;

	// Result slots: slot0 is the head shown on the output channel.
	itmb_pkg::result_t slot0_q;
	itmb_pkg::result_t slot1_q;
	logic [1:0]        count_q;

	logic              pop;
	logic              advance;

	// Step logic signals.
	logic        is_start;
	logic        is_trace;
	logic        is_finish;
	logic        is_ins;
	logic [31:0] trace_p;
	logic [31:0] trace_run;
	logic [31:0] finish_run;
	logic [31:0] run;
	logic        has_block;
	logic [31:0] trace_a_next;
	logic [31:0] trace_b_next;
	logic        pos_changed;
	logic [31:0] mismatch_sum;
	logic [31:0] match_sum;
	logic [31:0] match_half;
	logic [30:0] blocks_next;
	logic [31:0] start_mn;
	itmb_pkg::result_t block_res;
	itmb_pkg::result_t summary_res;
	itmb_pkg::result_t load0;
	logic [1:0]        load_count;

	// Handshake control.
	assign pop          = result.valid && result.ready;
	assign advance      = valid_s1 && (count_q == 2'd0 || (count_q == 2'd1 && pop));
	assign item.ready   = !valid_s1 || advance;
	assign result.valid = count_q != 2'd0;
	assign result.data  = slot0_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	// Decode and run arithmetic for the registered item.
	always_comb begin
		is_start  = item_s1.opcode == itmb_pkg::OP_START;
		is_trace  = item_s1.opcode == itmb_pkg::OP_TRACE;
		is_finish = item_s1.opcode == itmb_pkg::OP_FINISH;
		is_ins    = item_s1.trace_value[31];
		trace_p   = $unsigned(item_s1.trace_value);

		// An insertion ends the run on A, a deletion ends it on B.
		if (is_ins) begin
			trace_run    = 32'd0 - (trace_p + a_cursor_q);
			trace_a_next = 32'd0 - trace_p;
			trace_b_next = b_cursor_q + trace_run + 32'd1;
		end else begin
			trace_run    = trace_p - b_cursor_q;
			trace_a_next = a_cursor_q + trace_run + 32'd1;
			trace_b_next = trace_p;
		end
		pos_changed = trace_p != previous_value_q;

		finish_run = {1'b0, a_end_q} - a_cursor_q + 32'd1;
		run        = is_finish ? finish_run : trace_run;
		has_block  = (is_trace || is_finish) && run != 32'd0 && !run[31];
	end

	// Summary arithmetic: S = diff - indel, X = M+N+indel-2*diff halved toward zero.
	always_comb begin
		mismatch_sum = diff_total_q - indel_total_q;
		match_sum    = mn_term_q + indel_total_q;
		match_half   = $unsigned($signed(match_sum + {31'd0, match_sum[31]}) >>> 1);
		blocks_next  = blocks_seen_q + {30'd0, has_block};
		start_mn     = ({1'b0, item_s1.a_end} - {1'b0, item_s1.a_begin})
			+ ({1'b0, item_s1.b_end} - {1'b0, item_s1.b_begin})
			- {item_s1.diff_total, 1'b0};
	end

	// Result assembly.
	always_comb begin
		block_res            = '0;
		block_res.kind       = itmb_pkg::KIND_BLOCK;
		block_res.block_size = run[30:0];
		block_res.a_start    = a_cursor_q[30:0];
		block_res.b_start    = b_cursor_q[30:0];

		summary_res             = '0;
		summary_res.kind        = itmb_pkg::KIND_SUMMARY;
		summary_res.matches_res = $signed(match_half);
		summary_res.mismatches  = $signed(mismatch_sum);
		summary_res.ins_runs    = ins_run_total_q;
		summary_res.ins_count   = ins_total_q[30:0];
		summary_res.del_runs    = del_run_total_q;
		summary_res.del_count   = del_total_q[30:0];
		summary_res.block_count = blocks_next;
		summary_res.last        = 1'b1;

		load0      = has_block ? block_res : summary_res;
		load_count = {1'b0, has_block} + {1'b0, is_finish};
	end

	// Result slots: load on advance, otherwise shift on each output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (advance) begin
			count_q <= load_count;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slot0_q <= load0;
			slot1_q <= summary_res;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	// Alignment state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cursor_q       <= '0;
			b_cursor_q       <= '0;
			previous_value_q <= '0;
			ins_total_q      <= '0;
			del_total_q      <= '0;
			indel_total_q    <= '0;
			ins_run_total_q  <= '0;
			del_run_total_q  <= '0;
			blocks_seen_q    <= '0;
			a_end_q          <= '0;
			diff_total_q     <= '0;
			mn_term_q        <= '0;
		end else if (advance) begin
			if (is_start) begin
				a_end_q          <= item_s1.a_end;
				diff_total_q     <= {1'b0, item_s1.diff_total};
				mn_term_q        <= start_mn;
				a_cursor_q       <= {1'b0, item_s1.a_begin} + 32'd1;
				b_cursor_q       <= {1'b0, item_s1.b_begin} + 32'd1;
				previous_value_q <= '0;
				ins_total_q      <= '0;
				del_total_q      <= '0;
				indel_total_q    <= '0;
				ins_run_total_q  <= '0;
				del_run_total_q  <= '0;
				blocks_seen_q    <= '0;
			end else if (is_trace) begin
				a_cursor_q       <= trace_a_next;
				b_cursor_q       <= trace_b_next;
				previous_value_q <= trace_p;
				indel_total_q    <= indel_total_q + 32'd1;
				blocks_seen_q    <= blocks_next;
				if (is_ins) begin
					ins_total_q     <= ins_total_q + 32'd1;
					ins_run_total_q <= ins_run_total_q + {30'd0, pos_changed};
				end else begin
					del_total_q     <= del_total_q + 32'd1;
					del_run_total_q <= del_run_total_q + {30'd0, pos_changed};
				end
			end else if (is_finish) begin
				blocks_seen_q <= blocks_next;
			end
		end
	end

	// The slot count never holds more than the two results of a finish.
	`ITMB_ASSERT(a_count_range, clk, arst_n, count_q != 2'd3)
	// A second pending result is always the summary.
	`ITMB_ASSERT(a_slot1_summary, clk, arst_n,
		count_q != 2'd2 || (slot1_q.kind == itmb_pkg::KIND_SUMMARY && slot1_q.last))
	// The final flag only ever rides on a summary.
	`ITMB_ASSERT(a_last_summary, clk, arst_n,
		!(result.valid && result.data.last) || result.data.kind == itmb_pkg::KIND_SUMMARY)
	// A finish always leaves at least one result pending.
	`ITMB_ASSERT_NEXT(a_finish_result, clk, arst_n, advance && is_finish, count_q != 2'd0)
	// A deletion puts the B cursor at the trace position.
	`ITMB_ASSERT_NEXT(a_del_cursor, clk, arst_n, advance && is_trace && !is_ins,
		b_cursor_q == $past(trace_p))

endmodule
`default_nettype wire
